FILE: design/assert_macros.svh
// assertion macros shared by the url encoder blocks
// expects signals clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the same cycle as the trigger
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/uea_pkg.sv
// shared types, constants and encode functions for the url encoder with adler-32
// no dependencies
package uea_pkg;

    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [15:0] LOW_INIT  = 16'd1;
    localparam logic [15:0] HIGH_INIT = 16'd0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;   // 'A' - 10

    // control from the sequencer to the checksum unit
    typedef struct packed {
        logic       fold;
        logic [7:0] data;
        logic       finish;
    } adler_ctl_t;

    // up to three encoded bytes for one raw byte
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
    } enc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
        begin
            d = CH_ZERO + {4'b0000, n};
        end
        else
        begin
            d = HEX_ALPHA_BASE + {4'b0000, n};
        end
        return d;
    endfunction

    function automatic logic passes_through(input logic [7:0] c);
        logic p;
        p = (c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ], [CH_ZERO:CH_NINE],
                       CH_DASH, CH_UNDER, CH_DOT, CH_TILDE});
        return p;
    endfunction

    function automatic enc_t encode_byte(input logic [7:0] c);
        enc_t e;
        e = '0;
        if (passes_through(c))
        begin
            e.b0    = c;
            e.count = 2'd1;
        end
        else if (c == CH_SPACE)
        begin
            e.b0    = CH_PLUS;
            e.count = 2'd1;
        end
        else
        begin
            e.b0    = CH_PCT;
            e.b1    = hex_digit(c[7:4]);
            e.b2    = hex_digit(c[3:0]);
            e.count = 2'd3;
        end
        return e;
    endfunction

endpackage

FILE: design/uea_in_if.sv
// input channel of the url encoder: raw bytes with end marker
// no dependencies
interface uea_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_string;

    modport source (output valid, output byte_value, output has_byte,
                    output end_of_string, input ready);
    modport sink   (input valid, input byte_value, input has_byte,
                    input end_of_string, output ready);
endinterface

FILE: design/uea_out_if.sv
// output channel of the url encoder: encoded bytes and checksum
// no dependencies
interface uea_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  encoded_byte;
    logic        encoded_valid;
    logic [31:0] checksum;
    logic        checksum_valid;
    logic        run_last;

    modport source (output valid, output encoded_byte, output encoded_valid,
                    output checksum, output checksum_valid, output run_last,
                    input ready);
    modport sink   (input valid, input encoded_byte, input encoded_valid,
                    input checksum, input checksum_valid, input run_last,
                    output ready);
endinterface

FILE: design/uea_adler.sv
// running adler-32 over encoded bytes, one byte folded per cycle while fold is set
// depends on uea_pkg and assert_macros.svh
`include "assert_macros.svh"

module uea_adler
    import uea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  adler_ctl_t  ctl,
    output logic [31:0] checksum
);

    logic [15:0] sum_low_reg,  sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;
    logic [16:0] low_sum, high_sum;
    logic [15:0] low_fold, high_fold;
    logic [15:0] low_new, high_new;

    // low sum: add byte, one conditional subtract of the modulus
    always_comb
    begin
        low_sum = {1'b0, sum_low_reg} + {9'b0, ctl.data};
        if (low_sum >= {1'b0, ADLER_MOD})
        begin
            low_fold = 16'(low_sum - {1'b0, ADLER_MOD});
        end
        else
        begin
            low_fold = low_sum[15:0];
        end
    end

    // high sum: add the updated low sum, same reduction
    always_comb
    begin
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_fold};
        if (high_sum >= {1'b0, ADLER_MOD})
        begin
            high_fold = 16'(high_sum - {1'b0, ADLER_MOD});
        end
        else
        begin
            high_fold = high_sum[15:0];
        end
    end

    assign low_new  = ctl.fold ? low_fold  : sum_low_reg;
    assign high_new = ctl.fold ? high_fold : sum_high_reg;
    assign checksum = {high_new, low_new};

    // sums restart after the end of a string
    always_comb
    begin
        if (ctl.finish)
        begin
            sum_low_next  = LOW_INIT;
            sum_high_next = HIGH_INIT;
        end
        else
        begin
            sum_low_next  = low_new;
            sum_high_next = high_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg  <= LOW_INIT;
            sum_high_reg <= HIGH_INIT;
        end
        else
        begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
        end
    end

    `ASSERT_ALWAYS(a_low_in_range, sum_low_reg < ADLER_MOD, "low sum out of range")
    `ASSERT_ALWAYS(a_high_in_range, sum_high_reg < ADLER_MOD, "high sum out of range")
    `ASSERT_NEXT(a_finish_restart, ctl.finish, sum_low_reg == LOW_INIT && sum_high_reg == HIGH_INIT, "sums not restarted after end of string")

endmodule

FILE: design/url_encode_adler32_unit.sv
// top level of the url encoder with running adler-32 checksum
// depends on uea_pkg, uea_in_if, uea_out_if, uea_adler and assert_macros.svh
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  raw     | in  | byte_value, has_byte, end_of_string
//  enc     | out | encoded_byte, encoded_valid, checksum, checksum_valid, run_last
//
//  a pass-through byte, a space or a bare end marker gives one result, an escaped
//  byte three: the output register takes one result beat per cycle unless stalled
//  an idle beat (no byte, no end marker) is taken and yields nothing
//  the next raw beat is taken in the cycle the last result of the current one
//  moves into the output register, so a stalled output holds one pending item
//  reset sets the sums to 1 and 0 and empties both registers at once
`include "assert_macros.svh"

module url_encode_adler32_unit
    import uea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    uea_in_if.sink    raw,
    uea_out_if.source enc
);

    // item register: encoded bytes of the item being emitted
    logic       hold_valid_reg, hold_valid_next;
    logic [1:0] hold_idx_reg,   hold_idx_next;
    logic [7:0] hold_bytes_reg [3];
    logic [1:0] hold_count_reg;
    logic       hold_eos_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  enc_byte_reg;
    logic        enc_valid_reg;
    logic [31:0] chk_reg;
    logic        chk_valid_reg;
    logic        last_reg;

    logic        out_free, advance, accept, item_live;
    logic [1:0]  hold_nres;
    logic        piece_final, piece_has;
    logic [7:0]  piece_byte;
    enc_t        item_enc;
    logic [1:0]  item_count;
    adler_ctl_t  adler_ctl;
    logic [31:0] checksum;

    // handshake and sequencing
    assign hold_nres   = (hold_count_reg == 2'd0) ? 2'd1 : hold_count_reg;
    assign piece_final = (hold_idx_reg == hold_nres - 2'd1);
    assign piece_has   = (hold_idx_reg < hold_count_reg);
    assign piece_byte  = hold_bytes_reg[hold_idx_reg];
    assign out_free    = !out_valid_reg || enc.ready;
    assign advance     = hold_valid_reg && out_free;
    assign raw.ready   = !hold_valid_reg || (advance && piece_final);
    assign accept      = raw.valid && raw.ready;

    // encode the incoming byte
    assign item_enc   = encode_byte(raw.byte_value);
    assign item_count = raw.has_byte ? item_enc.count : 2'd0;
    assign item_live  = raw.has_byte || raw.end_of_string;

    // item register control
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        if (accept)
        begin
            hold_valid_next = item_live;
            hold_idx_next   = 2'd0;
        end
        else if (advance)
        begin
            if (piece_final)
            begin
                hold_valid_next = 1'b0;
            end
            else
            begin
                hold_idx_next = hold_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_idx_reg   <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            hold_idx_reg   <= hold_idx_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_bytes_reg[0] <= item_enc.b0;
            hold_bytes_reg[1] <= item_enc.b1;
            hold_bytes_reg[2] <= item_enc.b2;
            hold_count_reg    <= item_count;
            hold_eos_reg      <= raw.end_of_string;
        end
    end

    // checksum unit folds each byte as it enters the result register
    assign adler_ctl.fold   = advance && piece_has;
    assign adler_ctl.data   = piece_byte;
    assign adler_ctl.finish = advance && piece_final && hold_eos_reg;

    uea_adler u_adler
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (adler_ctl),
        .checksum (checksum)
    );

    // result register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (enc.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enc_byte_reg  <= piece_has ? piece_byte : 8'd0;
            enc_valid_reg <= piece_has;
            chk_reg       <= adler_ctl.finish ? checksum : 32'd0;
            chk_valid_reg <= adler_ctl.finish;
            last_reg      <= piece_final;
        end
    end

    assign enc.valid          = out_valid_reg;
    assign enc.encoded_byte   = enc_byte_reg;
    assign enc.encoded_valid  = enc_valid_reg;
    assign enc.checksum       = chk_reg;
    assign enc.checksum_valid = chk_valid_reg;
    assign enc.run_last       = last_reg;

    `ASSERT_IMPLY(a_idx_in_item, hold_valid_reg, hold_idx_reg < hold_nres, "result index past item end")
    `ASSERT_IMPLY(a_take_on_final, accept && hold_valid_reg, advance && piece_final, "new beat taken before current item finished")
    `ASSERT_IMPLY(a_chk_on_last, out_valid_reg && chk_valid_reg, last_reg, "checksum on a result that is not last")

endmodule

FILE: tb/tb.sv
// self-checking testbench for url_encode_adler32_unit: percent encoding and adler-32
// depends on uea_pkg, uea_in_if, uea_out_if and the design sources
`timescale 1ns / 1ps

module tb;
    import uea_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 16;
    localparam int MAX_PRINTED  = 40;

    localparam logic [7:0] HEX_DIGITS [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                              "8", "9", "A", "B", "C", "D", "E", "F"};

    // one raw beat as offered on the input channel
    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       end_of_string;
    } raw_beat_t;

    // one result beat as seen on the output channel
    typedef struct packed {
        logic [7:0]  encoded_byte;
        logic        encoded_valid;
        logic [31:0] checksum;
        logic        checksum_valid;
        logic        run_last;
    } enc_beat_t;

    logic clk;
    logic rst_n;

    uea_in_if  raw_if ();
    uea_out_if enc_if ();

    url_encode_adler32_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .enc   (enc_if)
    );

    raw_beat_t raw_pending[$];
    enc_beat_t expected_encoding[$];

    // running adler-32 sums of the predictor
    logic [15:0] adler_low;
    logic [15:0] adler_high;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;

    int items_queued;
    int idle_queued;
    int beats_taken;
    int results_checked;
    int checksums_checked;
    int mismatches;
    int cycle_count;

    // clock
    always
    begin
        #1 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("url_encode_adler32_unit: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("[%0t] %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic bit is_unreserved(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

    // fold one encoded byte into the sums, both kept below the modulus
    function automatic void fold_byte(input logic [7:0] c);
        logic [16:0] s;
        s = {1'b0, adler_low} + {9'b0, c};
        if (s >= {1'b0, ADLER_MOD})
        begin
            s = s - {1'b0, ADLER_MOD};
        end
        adler_low = s[15:0];
        s = {1'b0, adler_high} + {1'b0, adler_low};
        if (s >= {1'b0, ADLER_MOD})
        begin
            s = s - {1'b0, ADLER_MOD};
        end
        adler_high = s[15:0];
    endfunction

    // expected result beats for one accepted raw beat
    function automatic void encode_and_fold(input raw_beat_t b);
        logic [7:0] out_bytes [3];
        int n_bytes;
        int n_results;
        enc_beat_t r;
        n_bytes = 0;
        if (b.has_byte)
        begin
            if (is_unreserved(b.byte_value))
            begin
                out_bytes[0] = b.byte_value;
                n_bytes = 1;
            end
            else if (b.byte_value == CH_SPACE)
            begin
                out_bytes[0] = CH_PLUS;
                n_bytes = 1;
            end
            else
            begin
                out_bytes[0] = CH_PCT;
                out_bytes[1] = HEX_DIGITS[b.byte_value[7:4]];
                out_bytes[2] = HEX_DIGITS[b.byte_value[3:0]];
                n_bytes = 3;
            end
        end
        for (int k = 0; k < n_bytes; k++)
        begin
            fold_byte(out_bytes[k]);
        end
        n_results = (n_bytes == 0 && b.end_of_string) ? 1 : n_bytes;
        for (int k = 0; k < n_results; k++)
        begin
            r = '0;
            if (k < n_bytes)
            begin
                r.encoded_byte  = out_bytes[k];
                r.encoded_valid = 1'b1;
            end
            if (k == n_results - 1)
            begin
                r.run_last = 1'b1;
                if (b.end_of_string)
                begin
                    r.checksum       = {adler_high, adler_low};
                    r.checksum_valid = 1'b1;
                end
            end
            expected_encoding.push_back(r);
        end
        if (b.end_of_string)
        begin
            adler_low  = LOW_INIT;
            adler_high = HIGH_INIT;
        end
    endfunction

    // raw beat driver, fed from the pending queue
    always @(posedge clk)
    begin : raw_driver
        raw_beat_t nxt;
        if (!rst_n)
        begin
            raw_if.valid <= 1'b0;
        end
        else if (!raw_if.valid || raw_if.ready)
        begin
            if (raw_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = raw_pending.pop_front();
                raw_if.valid         <= 1'b1;
                raw_if.byte_value    <= nxt.byte_value;
                raw_if.has_byte      <= nxt.has_byte;
                raw_if.end_of_string <= nxt.end_of_string;
            end
            else
            begin
                raw_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus requested long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            enc_if.ready <= 1'b0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen    <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            enc_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            enc_if.ready <= 1'b0;
        end
        else
        begin
            enc_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input beats, compare on output beats
    always @(posedge clk)
    begin : monitor
        raw_beat_t got_raw;
        enc_beat_t want;
        if (rst_n)
        begin
            if (raw_if.valid && raw_if.ready)
            begin
                got_raw = '{raw_if.byte_value, raw_if.has_byte, raw_if.end_of_string};
                beats_taken++;
                encode_and_fold(got_raw);
            end
            if (enc_if.valid && enc_if.ready)
            begin
                if (expected_encoding.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat byte %02h chk %08h",
                                              enc_if.encoded_byte, enc_if.checksum));
                end
                else
                begin
                    want = expected_encoding.pop_front();
                    results_checked++;
                    if (want.checksum_valid)
                    begin
                        checksums_checked++;
                    end
                    if (enc_if.encoded_byte !== want.encoded_byte)
                        report_mismatch($sformatf("encoded_byte %02h, want %02h",
                                                  enc_if.encoded_byte, want.encoded_byte));
                    if (enc_if.encoded_valid !== want.encoded_valid)
                        report_mismatch($sformatf("encoded_valid %b, want %b",
                                                  enc_if.encoded_valid, want.encoded_valid));
                    if (enc_if.checksum !== want.checksum)
                        report_mismatch($sformatf("checksum %08h, want %08h",
                                                  enc_if.checksum, want.checksum));
                    if (enc_if.checksum_valid !== want.checksum_valid)
                        report_mismatch($sformatf("checksum_valid %b, want %b",
                                                  enc_if.checksum_valid, want.checksum_valid));
                    if (enc_if.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  enc_if.run_last, want.run_last));
                end
            end
        end
    end

    task automatic queue_beat(input logic [7:0] c, input logic has, input logic eos);
        raw_pending.push_back('{c, has, eos});
        if (has || eos)
        begin
            items_queued++;
        end
        else
        begin
            idle_queued++;
        end
    endtask

    // byte drawn from a mix of the encoder's character classes
    function automatic logic [7:0] random_string_byte();
        logic [7:0] c;
        case ($urandom_range(7))
            0: c = CH_UA + 8'($urandom_range(25));
            1: c = CH_LA + 8'($urandom_range(25));
            2: c = CH_ZERO + 8'($urandom_range(9));
            3:
            begin
                case ($urandom_range(3))
                    0: c = CH_DASH;
                    1: c = CH_UNDER;
                    2: c = CH_DOT;
                    default: c = CH_TILDE;
                endcase
            end
            4: c = CH_SPACE;
            5: c = 8'($urandom_range(127));
            6: c = 8'h80 + 8'($urandom_range(127));
            default: c = 8'($urandom_range(255));
        endcase
        return c;
    endfunction

    // well-formed string, ended on its last byte or by a bare end marker
    task automatic queue_string(input int len);
        bit bare;
        bare = (len == 0) || ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_beat(8'($urandom()), 1'b0, 1'b0);
            end
            queue_beat(random_string_byte(), 1'b1, (k == len - 1) && !bare);
        end
        if (bare)
        begin
            queue_beat(8'($urandom()), 1'b0, 1'b1);
        end
    endtask

    // long run of escaped high bytes so the high sum wraps past the modulus many times
    task automatic queue_wrap_string(input int len);
        logic [1:0] r;
        for (int k = 0; k < len; k++)
        begin
            r = 2'($urandom());
            queue_beat({3'b111, r[1], 3'b111, r[0]}, 1'b1, k == len - 1);
        end
    endtask

    task automatic queue_random(input int n_items);
        int start;
        start = items_queued;
        while (items_queued - start < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                queue_string($urandom_range(10));
            end
            else
            begin
                queue_beat(8'($urandom()), 1'($urandom()), 1'($urandom()));
            end
        end
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // sender stays quiet until every expected result has come
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (raw_pending.size() != 0 || raw_if.valid || expected_encoding.size() != 0);
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        raw_if.valid         = 1'b0;
        raw_if.byte_value    = 8'h00;
        raw_if.has_byte      = 1'b0;
        raw_if.end_of_string = 1'b0;
        enc_if.ready         = 1'b0;
        adler_low            = LOW_INIT;
        adler_high           = HIGH_INIT;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_requests        = 0;
        hold_seen            = 0;
        hold_left            = 0;
        items_queued         = 0;
        idle_queued          = 0;
        beats_taken          = 0;
        results_checked      = 0;
        checksums_checked    = 0;
        mismatches           = 0;
        cycle_count          = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty string, idle beat, byte extremes, class boundaries
        set_idling(0, 0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'hA5, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'h80, 1'b1, 1'b0);
        queue_beat(8'h7F, 1'b1, 1'b0);
        queue_beat(CH_SPACE, 1'b1, 1'b0);
        queue_beat(CH_UA, 1'b1, 1'b0);
        queue_beat(CH_UZ, 1'b1, 1'b0);
        queue_beat(CH_LA, 1'b1, 1'b0);
        queue_beat(CH_LZ, 1'b1, 1'b0);
        queue_beat(CH_ZERO, 1'b1, 1'b0);
        queue_beat(CH_NINE, 1'b1, 1'b0);
        queue_beat(CH_DASH, 1'b1, 1'b0);
        queue_beat(CH_UNDER, 1'b1, 1'b0);
        queue_beat(CH_DOT, 1'b1, 1'b0);
        queue_beat(CH_TILDE, 1'b1, 1'b0);
        queue_beat(CH_UA - 8'd1, 1'b1, 1'b0);
        queue_beat(CH_UZ + 8'd1, 1'b1, 1'b0);
        queue_beat(CH_LA - 8'd1, 1'b1, 1'b0);
        queue_beat(CH_LZ + 8'd1, 1'b1, 1'b0);
        queue_beat(CH_ZERO - 8'd1, 1'b1, 1'b0);
        queue_beat(CH_NINE + 8'd1, 1'b1, 1'b0);
        queue_beat(CH_PLUS, 1'b1, 1'b1);
        queue_beat(8'hFF, 1'b0, 1'b1);
        queue_beat(CH_SPACE, 1'b1, 1'b1);
        wait_drained();

        // no idling: modulus wrap string, then random strings
        queue_wrap_string(120);
        queue_random(45);
        wait_drained();

        // sender idles
        set_idling(67, 0);
        queue_random(45);
        wait_drained();

        // receiver stalls, opened by a long hold-off while the sender keeps offering
        set_idling(0, 67);
        hold_requests = hold_requests + 1;
        queue_random(45);
        wait_drained();

        // both sides idle
        set_idling(28, 28);
        queue_random(45);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_encoding.size() != 0)
        begin
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_encoding.size()));
        end
        $display("sent %0d raw beats (%0d idle) through five idling phases",
                 beats_taken, idle_queued);
        $display("checked %0d result beats, %0d of them carrying a checksum",
                 results_checked, checksums_checked);
        if (mismatches == 0)
        begin
            $display("url_encode_adler32_unit: match");
        end
        else
        begin
            $display("url_encode_adler32_unit: mismatch");
        end
        $finish;
    end

endmodule
